@@ hw/rtl/rcfd_pkg.sv @@
// rcfd_pkg: types, register indexes, codes and reset values for the
// remote-control frame decoder. No dependencies; used by every rtl file but rcfd_if.sv.
package rcfd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSyncValue    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBlinkTicks   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegServoBase    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegServoLeftPos = 3'd3;
  localparam logic [CfgIdxW-1:0] RegServoRightPos = 3'd4;

  // request opcodes
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // reset values
  localparam logic [7:0] SyncValueRst     = 8'hF0;
  localparam logic [3:0] BlinkTicksRst    = 4'd10;
  localparam logic [7:0] ServoBaseRst     = 8'd14;
  localparam logic [7:0] ServoLeftPosRst  = 8'd0;
  localparam logic [7:0] ServoRightPosRst = 8'd18;
  localparam logic [6:0] DriveDutyRst     = 7'd64;
  localparam logic [7:0] ServoPosRst      = 8'd9;

  typedef enum logic [1:0] {
    FRAME_IDLE  = 2'd0,
    FRAME_DRIVE = 2'd1,
    FRAME_SERVO = 2'd2,
    FRAME_LAMP  = 2'd3
  } frame_pos_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2
  } turn_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic       rx_error;
  } item_t;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [3:0] blink_ticks;
    logic [7:0] servo_base;
    logic [7:0] servo_left_pos;
    logic [7:0] servo_right_pos;
  } cfg_t;

  typedef struct packed {
    logic [1:0] direction;
    logic [6:0] duty_forward;
    logic [6:0] duty_reverse;
    logic       reverse_pin;
    logic [7:0] servo_compare;
    logic [5:0] lamp_bits;
    logic       brake_light;
    logic       left_lamp;
    logic       right_lamp;
  } res_t;

endpackage

@@ hw/rtl/rcfd_if.sv @@
// rcfd_in_if / rcfd_out_if: valid-ready channels for requests and results.
// Depends on nothing but plain logic types.
interface rcfd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  logic       rx_error;

  modport source (output valid, opcode, rx_byte, rx_error, input ready);
  modport sink   (input valid, opcode, rx_byte, rx_error, output ready);
endinterface

interface rcfd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] direction;
  logic [6:0] duty_forward;
  logic [6:0] duty_reverse;
  logic       reverse_pin;
  logic [7:0] servo_compare;
  logic [5:0] lamp_bits;
  logic       brake_light;
  logic       left_lamp;
  logic       right_lamp;

  modport source (output valid, direction, duty_forward, duty_reverse, reverse_pin,
                  servo_compare, lamp_bits, brake_light, left_lamp, right_lamp,
                  input ready);
  modport sink   (input valid, direction, duty_forward, duty_reverse, reverse_pin,
                  servo_compare, lamp_bits, brake_light, left_lamp, right_lamp,
                  output ready);
endinterface

@@ hw/rtl/rcfd_cfg_regs.sv @@
// rcfd_cfg_regs: configuration register file with a plain write port.
// Depends on rcfd_pkg.
module rcfd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rcfd_pkg::CfgDataW-1:0] cfg_data_i,
  output rcfd_pkg::cfg_t                cfg_o
);

  rcfd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rcfd_pkg::RegSyncValue:     cfg_d.sync_value      = cfg_data_i;
        rcfd_pkg::RegBlinkTicks:    cfg_d.blink_ticks     = cfg_data_i[3:0];
        rcfd_pkg::RegServoBase:     cfg_d.servo_base      = cfg_data_i;
        rcfd_pkg::RegServoLeftPos:  cfg_d.servo_left_pos  = cfg_data_i;
        rcfd_pkg::RegServoRightPos: cfg_d.servo_right_pos = cfg_data_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value      <= rcfd_pkg::SyncValueRst;
      cfg_q.blink_ticks     <= rcfd_pkg::BlinkTicksRst;
      cfg_q.servo_base      <= rcfd_pkg::ServoBaseRst;
      cfg_q.servo_left_pos  <= rcfd_pkg::ServoLeftPosRst;
      cfg_q.servo_right_pos <= rcfd_pkg::ServoRightPosRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/rcfd_state.sv @@
// rcfd_state: decoder state registers and the single-pass update that turns
// one registered request into the next state and its result. Depends on rcfd_pkg.
module rcfd_state (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  rcfd_pkg::item_t item_i,
  input  rcfd_pkg::cfg_t  cfg_i,
  output rcfd_pkg::res_t  res_o
);

  rcfd_pkg::frame_pos_e frame_q, frame_d;
  rcfd_pkg::dir_e       dir_q, dir_d;
  rcfd_pkg::turn_e      turn_q, turn_d;
  logic [6:0]           duty_q, duty_d;
  logic [7:0]           servo_q, servo_d;
  logic [5:0]           lamp_q, lamp_d;
  logic                 brake_q, brake_d;
  logic [3:0]           tick_q, tick_d;
  logic                 left_q, left_d;
  logic                 right_q, right_d;

  logic [3:0] tick_inc;
  logic       blink_evt;
  logic       is_sync;
  logic       hit_left;
  logic       hit_right;

  assign tick_inc  = tick_q + 4'd1;
  assign blink_evt = (tick_inc == cfg_i.blink_ticks);
  assign is_sync   = (item_i.rx_byte == cfg_i.sync_value);

  // next state
  always_comb begin
    frame_d = frame_q;
    dir_d   = dir_q;
    turn_d  = turn_q;
    duty_d  = duty_q;
    servo_d = servo_q;
    lamp_d  = lamp_q;
    brake_d = brake_q;
    tick_d  = tick_q;
    left_d  = left_q;
    right_d = right_q;

    if (item_i.opcode == rcfd_pkg::OpTick) begin
      tick_d = tick_inc;
      if (blink_evt) begin
        tick_d  = 4'd0;
        brake_d = 1'b0;
        if (turn_q == rcfd_pkg::TURN_LEFT) begin
          left_d = ~left_q;
        end else if (turn_q != rcfd_pkg::TURN_NONE) begin
          right_d = ~right_q;
        end
      end
    end else if (!item_i.rx_error) begin
      if (frame_q == rcfd_pkg::FRAME_IDLE) begin
        if (is_sync) begin
          frame_d = rcfd_pkg::FRAME_DRIVE;
        end
      end else if (is_sync) begin
        // sync mid-frame drops the frame without starting a new one
        frame_d = rcfd_pkg::FRAME_IDLE;
      end else begin
        case (frame_q)
          rcfd_pkg::FRAME_DRIVE: begin
            if (item_i.rx_byte[6]) begin
              dir_d = rcfd_pkg::DIR_REV;
            end else if (item_i.rx_byte[7]) begin
              dir_d = rcfd_pkg::DIR_FWD;
            end else begin
              dir_d = rcfd_pkg::DIR_STOP;
            end
            if (duty_q > {1'b0, item_i.rx_byte[5:0]}) begin
              brake_d = 1'b1;
            end
            duty_d  = {1'b0, item_i.rx_byte[5:0]};
            frame_d = rcfd_pkg::FRAME_SERVO;
          end
          rcfd_pkg::FRAME_SERVO: begin
            servo_d = item_i.rx_byte;
            frame_d = rcfd_pkg::FRAME_LAMP;
          end
          default: begin
            lamp_d  = item_i.rx_byte[5:0];
            frame_d = rcfd_pkg::FRAME_IDLE;
          end
        endcase
      end
    end

    // turn signal arming uses the position after this request
    hit_left  = (servo_d == cfg_i.servo_left_pos);
    hit_right = (servo_d == cfg_i.servo_right_pos);
    if (hit_left || hit_right) begin
      if (turn_q == rcfd_pkg::TURN_NONE) begin
        turn_d = hit_left ? rcfd_pkg::TURN_LEFT : rcfd_pkg::TURN_RIGHT;
      end
    end else if (turn_q != rcfd_pkg::TURN_NONE) begin
      turn_d  = rcfd_pkg::TURN_NONE;
      left_d  = 1'b0;
      right_d = 1'b0;
    end
  end

  // result from the updated state
  always_comb begin
    res_o.direction     = dir_d;
    res_o.duty_forward  = (dir_d == rcfd_pkg::DIR_FWD) ? duty_d : 7'd0;
    res_o.duty_reverse  = (dir_d == rcfd_pkg::DIR_REV) ? duty_d : 7'd0;
    res_o.reverse_pin   = (dir_d == rcfd_pkg::DIR_REV);
    res_o.servo_compare = cfg_i.servo_base + servo_d;
    res_o.lamp_bits     = lamp_d;
    res_o.brake_light   = (dir_d != rcfd_pkg::DIR_STOP) && brake_d;
    res_o.left_lamp     = left_d;
    res_o.right_lamp    = right_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= rcfd_pkg::FRAME_IDLE;
      dir_q   <= rcfd_pkg::DIR_STOP;
      turn_q  <= rcfd_pkg::TURN_NONE;
      duty_q  <= rcfd_pkg::DriveDutyRst;
      servo_q <= rcfd_pkg::ServoPosRst;
      lamp_q  <= 6'd0;
      brake_q <= 1'b0;
      tick_q  <= 4'd0;
      left_q  <= 1'b0;
      right_q <= 1'b0;
    end else if (step_i) begin
      frame_q <= frame_d;
      dir_q   <= dir_d;
      turn_q  <= turn_d;
      duty_q  <= duty_d;
      servo_q <= servo_d;
      lamp_q  <= lamp_d;
      brake_q <= brake_d;
      tick_q  <= tick_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

`ifndef SYNTHESIS
  // only the armed side can ever blink
  a_levels_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(left_q && right_q))
    else $error("both turn lamps lit");

  a_unarmed_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (turn_q == rcfd_pkg::TURN_NONE) |-> (!left_q && !right_q))
    else $error("turn lamp lit while unarmed");

  a_blink_clears_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (item_i.opcode == rcfd_pkg::OpTick) && blink_evt)
      |=> (!brake_q && (tick_q == 4'd0)))
    else $error("blink tick did not clear brake and counter");

  a_error_byte_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (item_i.opcode == rcfd_pkg::OpByte) && item_i.rx_error)
      |=> ($stable(frame_q) && $stable(duty_q) && $stable(servo_q) && $stable(lamp_q)))
    else $error("errored byte changed frame state");
`endif

endmodule

@@ hw/rtl/remote_control_frame_decoder.sv @@
// A request is taken into the request register, goes through the state update and
// is written to the result register. Throughput: one request per cycle while the
// sink takes results, set by the single state update between the two registers.
// A stalled sink holds the result, then the pending request, then the input.
// Reset (rst_ni, asynchronous, active low) empties both registers, loads the
// configuration defaults and returns the decoder state to its start values.
module remote_control_frame_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rcfd_pkg::CfgDataW-1:0] cfg_data_i,
  rcfd_in_if.sink                       in_i,
  rcfd_out_if.source                    out_o
);

  rcfd_pkg::cfg_t  cfg;
  rcfd_pkg::item_t item_q;
  rcfd_pkg::res_t  res_d, res_q;
  logic            req_valid_q, req_valid_d;
  logic            out_valid_q, out_valid_d;
  logic            step;
  logic            in_acc;

  rcfd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rcfd_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // a registered request moves on when the result register is free or draining
  assign step        = req_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !req_valid_q || step;
  assign in_acc      = in_i.valid && in_i.ready;
  assign req_valid_d = in_acc || (req_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.opcode   <= in_i.opcode;
      item_q.rx_byte  <= in_i.rx_byte;
      item_q.rx_error <= in_i.rx_error;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.direction     = res_q.direction;
  assign out_o.duty_forward  = res_q.duty_forward;
  assign out_o.duty_reverse  = res_q.duty_reverse;
  assign out_o.reverse_pin   = res_q.reverse_pin;
  assign out_o.servo_compare = res_q.servo_compare;
  assign out_o.lamp_bits     = res_q.lamp_bits;
  assign out_o.brake_light   = res_q.brake_light;
  assign out_o.left_lamp     = res_q.left_lamp;
  assign out_o.right_lamp    = res_q.right_lamp;

endmodule
